### design/text_console_writer_macros.svh
// Assertion helpers shared by the console design files.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold at every clock edge out of reset.
`define TCW_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

### design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int NCELLS       = COLS * ROWS;
    localparam int ADDR_W       = $clog2(NCELLS);
    localparam int PTR_W        = $clog2(NCELLS + 1);
    localparam int SCROLL_CELLS = COLS * (ROWS - 1);

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int RADDR_W = 11;
    localparam int OFF_W   = 11;
    localparam int CFG_W   = 4;

    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_BLANK    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    localparam logic [3:0] RESET_TEXT_COLOR = 4'hF;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_MOVE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_TEXT_COLOR   = 2'd0,
        CFG_BACK_COLOR   = 2'd1,
        CFG_BLINK_ENABLE = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

### design/tcw_if.sv
`timescale 1ns / 1ps

interface tcw_in_if;
    import tcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [CHAR_W-1:0]    char_code;
    logic [COL_W-1:0]     target_col;
    logic [ROW_W-1:0]     target_row;
    logic [RADDR_W-1:0]   read_address;

    modport source (
        output valid, action, char_code, target_col, target_row, read_address,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, target_col, target_row, read_address,
        output ready
    );
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CELL_W-1:0]   cell_value;
    logic [COL_W-1:0]    cursor_col;
    logic [ROW_W-1:0]    cursor_row;
    logic [OFF_W-1:0]    cursor_offset;

    modport source (
        output valid, cell_value, cursor_col, cursor_row, cursor_offset,
        input  ready
    );
    modport sink (
        input  valid, cell_value, cursor_col, cursor_row, cursor_offset,
        output ready
    );
endinterface

### design/tcw_screen_ram.sv
`timescale 1ns / 1ps

module tcw_screen_ram (
    input  logic                      clk,
    input  tcw_pkg::ram_req_t         req,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [NCELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/tcw_ctrl.sv
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]   cfg_data,
    tcw_in_if.sink                      req,
    tcw_out_if.source                   rsp,
    output tcw_pkg::ram_req_t           ram_req,
    input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);
    import tcw_pkg::*;

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]  dst_reg, dst_next;
    logic               pend_reg, pend_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_cell_reg, out_cell_next;

    logic [3:0]         text_reg;
    logic [2:0]         back_reg;
    logic               blink_reg;

    logic [CELL_W-1:0]  blank;
    logic [ADDR_W-1:0]  lin;
    logic               in_fire;

    // Write-char decode results.
    logic [COL_W:0]     wc_col;
    logic [ROW_W:0]     wc_row;
    logic               wc_we;
    logic [ADDR_W-1:0]  wc_addr;
    logic [CELL_W-1:0]  wc_data;
    logic               wc_scroll;

    assign blank   = {blink_reg, back_reg, text_reg, CHAR_BLANK};
    assign lin     = ADDR_W'(row_reg) * ADDR_W'(COLS) + ADDR_W'(col_reg);
    assign in_fire = req.valid && req.ready;

    assign req.ready         = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_value    = out_cell_reg;
    assign rsp.cursor_col    = col_reg;
    assign rsp.cursor_row    = row_reg;
    assign rsp.cursor_offset = OFF_W'(lin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg  <= RESET_TEXT_COLOR;
            back_reg  <= '0;
            blink_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEXT_COLOR:   text_reg  <= cfg_data[3:0];
                CFG_BACK_COLOR:   back_reg  <= cfg_data[2:0];
                CFG_BLINK_ENABLE: blink_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Cursor motion and the single cell write, if any, of one character.
    always_comb
    begin
        wc_col    = {1'b0, col_reg};
        wc_row    = {1'b0, row_reg};
        wc_we     = 1'b0;
        wc_addr   = lin;
        wc_data   = blank;
        wc_scroll = 1'b0;
        case (req.char_code)
            CHAR_CR:
            begin
                wc_col = '0;
            end
            CHAR_LF:
            begin
                wc_col = '0;
                wc_row = wc_row + 1'b1;
            end
            CHAR_BS:
            begin
                // At home the blank lands on cell 0 and the cursor stays put.
                wc_we   = 1'b1;
                wc_addr = (lin == '0) ? '0 : lin - 1'b1;
                if (col_reg != '0)
                begin
                    wc_col = wc_col - 1'b1;
                end
                else if (row_reg != '0)
                begin
                    wc_row = wc_row - 1'b1;
                    wc_col = (COL_W+1)'(COLS - 1);
                end
            end
            default:
            begin
                if (req.char_code >= CHAR_BLANK && req.char_code <= CHAR_PRINT_HI)
                begin
                    wc_we   = 1'b1;
                    wc_data = {1'b0, back_reg, text_reg, req.char_code};
                    wc_col  = wc_col + 1'b1;
                end
            end
        endcase
        if (int'(wc_col) >= COLS)
        begin
            wc_col = '0;
            wc_row = wc_row + 1'b1;
        end
        if (int'(wc_row) >= ROWS)
        begin
            wc_scroll = 1'b1;
            wc_row    = (ROW_W+1)'(ROWS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg      <= dst_next;
        out_cell_reg <= out_cell_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        pend_next      = 1'b0;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_cell_next  = out_cell_reg;
        ram_req        = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg[ADDR_W-1:0];
                ram_req.wdata = RESET_CELL;
                if (ptr_reg == PTR_W'(NCELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (action_t'(req.action))
                        ACT_WRITE:
                        begin
                            ram_req.we    = wc_we;
                            ram_req.waddr = wc_addr;
                            ram_req.wdata = wc_data;
                            col_next      = wc_col[COL_W-1:0];
                            row_next      = wc_row[ROW_W-1:0];
                            out_cell_next = '0;
                            if (wc_scroll)
                            begin
                                ptr_next   = PTR_W'(COLS);
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            col_next      = '0;
                            row_next      = '0;
                            ptr_next      = '0;
                            out_cell_next = '0;
                            state_next    = ST_FILL;
                        end
                        ACT_READ:
                        begin
                            rd_ok_next = int'(req.read_address) < NCELLS;
                            if (int'(req.read_address) < NCELLS)
                            begin
                                ram_req.raddr = ADDR_W'(req.read_address);
                            end
                            state_next = ST_READ;
                        end
                        ACT_MOVE:
                        begin
                            col_next = (int'(req.target_col) >= COLS) ? '0 : req.target_col;
                            row_next = (int'(req.target_row) > ROWS - 1) ?
                                       ROW_W'(ROWS - 1) : req.target_row;
                            out_cell_next  = '0;
                            out_valid_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                out_cell_next  = rd_ok_reg ? ram_rdata : '0;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // Read one row ahead, write the cell back one row up in the next cycle.
                if (pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = dst_reg;
                    ram_req.wdata = ram_rdata;
                end
                if (ptr_reg == PTR_W'(NCELLS))
                begin
                    ptr_next   = PTR_W'(SCROLL_CELLS);
                    state_next = ST_FILL;
                end
                else
                begin
                    ram_req.raddr = ptr_reg[ADDR_W-1:0];
                    dst_next      = ADDR_W'(ptr_reg - PTR_W'(COLS));
                    pend_next     = 1'b1;
                    ptr_next      = ptr_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg[ADDR_W-1:0];
                ram_req.wdata = blank;
                if (ptr_reg == PTR_W'(NCELLS - 1))
                begin
                    ptr_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    `TCW_ASSERT_ALWAYS(a_cursor_in_range, (int'(col_reg) < COLS) && (int'(row_reg) < ROWS), "cursor left the screen")
    `TCW_ASSERT_IMPLIES(a_write_in_range, ram_req.we, int'(ram_req.waddr) < NCELLS, "cell write beyond the screen")
    `TCW_ASSERT_IMPLIES(a_scroll_lag, (state_reg == ST_SCROLL) && pend_reg, int'(dst_reg) + COLS + 1 == int'(ptr_reg), "scroll copy lost its row offset")
    `TCW_ASSERT_IMPLIES(a_result_waits_idle, out_valid_reg, state_reg == ST_IDLE, "screen work while a result waits")
    `TCW_ASSERT_NEXT(a_read_answers, (state_reg == ST_READ), out_valid_reg, "read produced no result")

endmodule

### design/text_console_writer.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// req     | in  | action, char_code, target_col, target_row, read_address
// rsp     | out | cell_value, cursor_col, cursor_row, cursor_offset
// cfg     | in  | cfg_we, cfg_index, cfg_data (text, back, blink colors)
// One item at a time: a move, or a write char that does not scroll, answers from the idle state,
// a read goes through the read state (one screen RAM read). A scroll copies rows up and blanks
// the last row, and a clear blanks every cell, both through the single write port of the screen
// RAM, which sees one cell per cycle. After reset the block walks all COLS*ROWS cells (2000)
// before req.ready rises. A result held by a stalled rsp keeps req.ready low until it is taken.

module text_console_writer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]  cfg_data,
    tcw_in_if.sink                     req,
    tcw_out_if.source                  rsp
);
    import tcw_pkg::*;

    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rdata;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    tcw_screen_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;

    typedef struct {
        action_t             action;
        logic [CHAR_W-1:0]   code;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [RADDR_W-1:0]  addr;
    } command_t;

    typedef struct {
        logic [CELL_W-1:0] cell_val;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [OFF_W-1:0]  offset;
    } status_t;

    // Tracks the screen, the cursor and the colors, and holds the status
    // beats still owed by the block.
    class console_tracker;
        logic [CELL_W-1:0] screen [NCELLS];
        int unsigned       col;
        int unsigned       row;
        logic [3:0]        text_color;
        logic [2:0]        back_color;
        logic              blink;
        status_t           pending [$];
        int                mismatches;

        function new();
            foreach (screen[i]) screen[i] = RESET_CELL;
            col = 0;
            row = 0;
            text_color = RESET_TEXT_COLOR;
            back_color = 0;
            blink = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_TEXT_COLOR:   text_color = val;
                CFG_BACK_COLOR:   back_color = val[2:0];
                CFG_BLINK_ENABLE: blink = val[0];
                default: ;
            endcase
        endfunction

        function logic [CELL_W-1:0] blank_cell();
            return {blink, back_color, text_color, CHAR_BLANK};
        endfunction

        function void scroll_up();
            for (int i = 0; i < SCROLL_CELLS; i++) screen[i] = screen[i + COLS];
            for (int i = SCROLL_CELLS; i < NCELLS; i++) screen[i] = blank_cell();
        endfunction

        function void put_char(logic [CHAR_W-1:0] c);
            int unsigned lin;
            if (c == CHAR_CR) begin
                col = 0;
            end
            else if (c == CHAR_LF) begin
                col = 0;
                row++;
            end
            else if (c == CHAR_BS) begin
                lin = row * COLS + col;
                if (lin > 0) lin--;
                if (col > 0) begin
                    col--;
                end
                else if (row > 0) begin
                    row--;
                    col = COLS - 1;
                end
                screen[lin] = blank_cell();
            end
            else if (c >= CHAR_BLANK && c <= CHAR_PRINT_HI) begin
                // Printed characters never carry the blink bit.
                lin = row * COLS + col;
                screen[lin] = {1'b0, back_color, text_color, c};
                col++;
            end
            if (col >= COLS) begin
                col = 0;
                row++;
            end
            if (row >= ROWS) begin
                scroll_up();
                row = ROWS - 1;
            end
        endfunction

        function void note_command(command_t cmd);
            status_t     want;
            int unsigned c;
            int unsigned r;
            want.cell_val = '0;
            case (cmd.action)
                ACT_WRITE: put_char(cmd.code);
                ACT_CLEAR:
                begin
                    foreach (screen[i]) screen[i] = blank_cell();
                    col = 0;
                    row = 0;
                end
                ACT_READ:
                begin
                    if (cmd.addr < NCELLS) want.cell_val = screen[cmd.addr];
                end
                default:
                begin
                    c = cmd.col;
                    r = cmd.row;
                    if (c >= COLS) c = 0;
                    if (r > ROWS - 1) r = ROWS - 1;
                    col = c;
                    row = r;
                end
            endcase
            want.col = COL_W'(col);
            want.row = ROW_W'(row);
            want.offset = OFF_W'(row * COLS + col);
            pending.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_status(status_t got);
            status_t want;
            if (pending.size() == 0) begin
                report($sformatf("status beat with nothing expected (col %0d row %0d)",
                                 got.col, got.row));
            end
            else begin
                want = pending.pop_front();
                if (got.cell_val !== want.cell_val)
                    report($sformatf("cell_value got %h expected %h",
                                     got.cell_val, want.cell_val));
                if (got.col !== want.col)
                    report($sformatf("cursor_col got %0d expected %0d", got.col, want.col));
                if (got.row !== want.row)
                    report($sformatf("cursor_row got %0d expected %0d", got.row, want.row));
                if (got.offset !== want.offset)
                    report($sformatf("cursor_offset got %0d expected %0d",
                                     got.offset, want.offset));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    tcw_in_if  req_if ();
    tcw_out_if rsp_if ();

    text_console_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    console_tracker sb;
    bit             tx_gaps;
    bit             rx_stalls;
    bit             hold_output;
    int             quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic command_t make_cmd(action_t a, int code, int c, int r, int addr);
        command_t m;
        m.action = a;
        m.code = CHAR_W'(code);
        m.col = COL_W'(c);
        m.row = ROW_W'(r);
        m.addr = RADDR_W'(addr);
        return m;
    endfunction

    // Mostly printing and cursor motion, with half the reads aimed at or just before the cursor so
    // that they hit freshly written cells.
    function automatic command_t random_command();
        command_t    m;
        int unsigned pick;
        int unsigned off;
        int unsigned sel;
        m = make_cmd(ACT_WRITE, $urandom_range(0, 255), $urandom_range(0, 127),
                     $urandom_range(0, 31), $urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        off = sb.row * COLS + sb.col;
        if (pick < 2) begin
            m.action = ACT_CLEAR;
        end
        else if (pick < 22) begin
            m.action = ACT_READ;
            sel = $urandom_range(0, 3);
            if (sel < 2)
                m.addr = RADDR_W'(off >= 100 ? off - $urandom_range(0, 100)
                                             : $urandom_range(0, off));
            else if (sel == 2)
                m.addr = RADDR_W'($urandom_range(0, NCELLS - 1));
        end
        else if (pick < 32) begin
            m.action = ACT_MOVE;
            if ($urandom_range(0, 3) != 0) m.col = COL_W'($urandom_range(0, COLS - 1));
        end
        else begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                m.code = CHAR_LF;
            else if (sel < 13)
                m.code = CHAR_CR;
            else if (sel < 21)
                m.code = CHAR_BS;
            else if (sel < 28)
                m.code = CHAR_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                      : $urandom_range(128, 255));
            else
                m.code = CHAR_W'($urandom_range(32, 127));
        end
        return m;
    endfunction

    task send_command(command_t m);
        int n;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.action       <= m.action;
        req_if.char_code    <= m.code;
        req_if.target_col   <= m.col;
        req_if.target_row   <= m.row;
        req_if.read_address <= m.addr;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_command(m);
    endtask

    task wait_drained();
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task load_colors(logic [3:0] text, logic [2:0] back, logic blink);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TEXT_COLOR;
        cfg_data  <= text;
        @(posedge clk);
        cfg_index <= CFG_BACK_COLOR;
        cfg_data  <= {1'b0, back};
        @(posedge clk);
        cfg_index <= CFG_BLINK_ENABLE;
        cfg_data  <= {3'b000, blink};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_TEXT_COLOR, text);
        sb.set_reg(CFG_BACK_COLOR, {1'b0, back});
        sb.set_reg(CFG_BLINK_ENABLE, {3'b000, blink});
    endtask

    // Status receiver with random back-pressure and one long hold.
    initial
    begin
        int n;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_status('{rsp_if.cell_value, rsp_if.cursor_col,
                                  rsp_if.cursor_row, rsp_if.cursor_offset});
            if (hold_output) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
                rsp_if.ready <= 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run when no beat moves on either channel for too long.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] no beat for %0d cycles", $realtime, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        command_t directed [$];
        sb = new();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        hold_output = 1'b0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_TEXT_COLOR;
        cfg_data            <= '0;
        req_if.valid        <= 1'b0;
        req_if.action       <= ACT_WRITE;
        req_if.char_code    <= '0;
        req_if.target_col   <= '0;
        req_if.target_row   <= '0;
        req_if.read_address <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its screen memory before it takes the first command.
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);

        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, 0));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, 2047));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, NCELLS));
        directed.push_back(make_cmd(ACT_WRITE, CHAR_BS, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, 8'h41, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, CHAR_PRINT_HI, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, CHAR_BLANK, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, 8'h00, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, 8'hFF, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, 8'h80, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, 8'h1F, 0, 0, 0));
        directed.push_back(make_cmd(ACT_WRITE, CHAR_CR, 0, 0, 0));
        directed.push_back(make_cmd(ACT_MOVE, 0, 127, 31, 0));
        directed.push_back(make_cmd(ACT_WRITE, CHAR_BS, 0, 0, 0));
        directed.push_back(make_cmd(ACT_MOVE, 0, COLS - 1, ROWS - 1, 0));
        directed.push_back(make_cmd(ACT_WRITE, 8'h7E, 0, 0, 0));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, NCELLS - 1));
        directed.push_back(make_cmd(ACT_WRITE, CHAR_LF, 0, 0, 0));
        directed.push_back(make_cmd(ACT_MOVE, 0, COLS, 0, 0));
        directed.push_back(make_cmd(ACT_MOVE, 0, 0, ROWS, 0));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, SCROLL_CELLS - 1));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, SCROLL_CELLS));
        directed.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, NCELLS - 1));
        directed.push_back(make_cmd(ACT_READ, 0, 0, 0, 0));
        foreach (directed[i]) send_command(directed[i]);
        wait_drained();

        for (int p = 1; p <= PHASES; p++) begin
            if (p == 1)
                load_colors(4'hF, 3'd7, 1'b1);
            else if (p == 2)
                load_colors(4'h0, 3'd0, 1'b0);
            else
                load_colors(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                            1'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == PHASES) begin
                    tx_gaps = 1'b0;
                    rx_stalls = 1'b0;
                end
                else if (i % 25 == 0) begin
                    tx_gaps = ($urandom_range(0, 3) != 0);
                    rx_stalls = ($urandom_range(0, 3) != 0);
                end
                // Hold the status side so that the command side backs up.
                if (p == 3 && i == 10) hold_output = 1'b1;
                if (p == 4 && i == 50) wait_drained();
                send_command(random_command());
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d status beats never arrived", sb.pending.size()));
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
